// ----- rtl/core/vssl_pkg.sv -----
// Shared types and constants of the velocity setpoint slew limiter.
package vssl_pkg;

  localparam int unsigned LIM_W    = 15;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 16;
  localparam int unsigned REQ_W    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_CMD      = 2'd0,
    REQ_OVERRIDE = 2'd1,
    REQ_TICK     = 2'd2
  } req_type_e;

  localparam logic [CFG_AW-1:0] CFG_MAX_HORIZ = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_MAX_VERT  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_MAX_TURN  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_STEP      = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_TIMEOUT   = 3'd4;

  localparam logic [LIM_W-1:0]  RST_MAX_HORIZ = 15'd1500;
  localparam logic [LIM_W-1:0]  RST_MAX_VERT  = 15'd500;
  localparam logic [LIM_W-1:0]  RST_MAX_TURN  = 15'd1000;
  localparam logic [LIM_W-1:0]  RST_STEP      = 15'd40;
  localparam logic [TICK_W-1:0] RST_TIMEOUT   = 16'd12;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

endpackage

// ----- rtl/core/vssl_axis.sv -----
// One axis: symmetric clamp of the desired rate, then step-limited move of the current rate.
module vssl_axis #(
  parameter int unsigned RW = 16
) (
  input  logic signed [RW-1:0]            cur_i,
  input  logic signed [RW-1:0]            want_i,
  input  logic [vssl_pkg::LIM_W-1:0]      lim_i,
  input  logic [vssl_pkg::LIM_W-1:0]      step_i,
  output logic signed [RW-1:0]            next_o
);
  import vssl_pkg::*;

  localparam int unsigned EW = ((RW > 16) ? RW : 16) + 2;

  logic signed [EW-1:0] want_e, cur_e, lim_e, step_e, clamp_e, up_e, dn_e, next_e;

  always_comb begin
    want_e = EW'(want_i);
    cur_e  = EW'(cur_i);
    lim_e  = signed'(EW'(lim_i));
    step_e = signed'(EW'(step_i));
    if (want_e > lim_e) begin
      clamp_e = lim_e;
    end else if (want_e < -lim_e) begin
      clamp_e = -lim_e;
    end else begin
      clamp_e = want_e;
    end
    up_e = cur_e + step_e;
    dn_e = cur_e - step_e;
    if (clamp_e > cur_e) begin
      next_e = (up_e < clamp_e) ? up_e : clamp_e;
    end else begin
      next_e = (dn_e > clamp_e) ? dn_e : clamp_e;
    end
    next_o = next_e[RW-1:0];
  end

endmodule

// ----- rtl/core/velocity_setpoint_slew_limiter_unit.sv -----
// Top level of the four-axis velocity setpoint slew limiter.
//
// Requests enter on the s_axis channel: tuser carries the request type
// (command, vertical override, tick), tdata the five rate fields. Only a
// tick request produces a result, the four smoothed rates on m_axis.
// Commands store targets and clear the tick counter; overrides store vz.
// A request is taken into an input register and processed from there by
// a single pass of clamp and slew logic per axis; a tick result is held
// in the result register, which drives m_axis. Throughput is one request
// per cycle while the receiver does not stall, set by the input register
// feeding the result register directly. If the receiver stalls with a
// result pending, the result register holds it; a further tick waits in
// the input register, and s_axis_tready_o drops only while both are full.
// Non-tick requests still drain. Reset clears all rates, the override,
// the tick counter and both valid flags, and loads the register defaults.
// The config port is a plain write port, written only while the block is
// idle: the user must keep to this, as the block does not enforce it.
module velocity_setpoint_slew_limiter_unit #(
  parameter int unsigned RATE_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vssl_pkg::CFG_AW-1:0]      cfg_addr_i,
  input  logic [vssl_pkg::CFG_DW-1:0]      cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // cmd_vx, cmd_vy, cmd_vz, cmd_yaw, override_vz, zero pad
  input  logic [((5*RATE_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // req_type
  input  logic [vssl_pkg::REQ_W-1:0]       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // out_vx, out_vy, out_vz, out_yaw, zero pad
  output logic [((4*RATE_WIDTH+7)/8)*8-1:0] m_axis_tdata_o
);
  import vssl_pkg::*;

  localparam int unsigned RW    = RATE_WIDTH;
  localparam int unsigned AXES  = 4;
  localparam int unsigned AX_Z  = 2;
  localparam int unsigned OUT_W = ((4*RATE_WIDTH+7)/8)*8;

  logic [LIM_W-1:0]  max_h_q, max_v_q, max_t_q, step_q;
  logic [TICK_W-1:0] timeout_q;

  logic                 in_valid_q;
  logic [REQ_W-1:0]     in_type_q;
  logic signed [RW-1:0] in_cmd_q [AXES];
  logic signed [RW-1:0] in_ovr_q;

  logic signed [RW-1:0] target_q [AXES];
  logic signed [RW-1:0] target_d [AXES];
  logic signed [RW-1:0] cur_q    [AXES];
  logic signed [RW-1:0] cur_d    [AXES];
  logic signed [RW-1:0] want     [AXES];
  logic signed [RW-1:0] next_rate[AXES];
  logic [LIM_W-1:0]     lim      [AXES];
  logic signed [RW-1:0] ovr_q, ovr_d;
  logic                 ovr_on_q, ovr_on_d;
  logic [TICK_W-1:0]    ticks_q, ticks_d;
  logic [TICK_W-1:0]    ticks_d_r;
  logic                 stale;

  logic                 out_valid_q, out_valid_d;
  logic [OUT_W-1:0]     out_data_q, out_data_d;

  logic is_tick, fire, in_take;

  assign is_tick         = (in_type_q == REQ_TICK);
  assign fire            = in_valid_q && (!is_tick || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_h_q   <= RST_MAX_HORIZ;
      max_v_q   <= RST_MAX_VERT;
      max_t_q   <= RST_MAX_TURN;
      step_q    <= RST_STEP;
      timeout_q <= RST_TIMEOUT;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_MAX_HORIZ: max_h_q   <= cfg_wdata_i[LIM_W-1:0];
        CFG_MAX_VERT:  max_v_q   <= cfg_wdata_i[LIM_W-1:0];
        CFG_MAX_TURN:  max_t_q   <= cfg_wdata_i[LIM_W-1:0];
        CFG_STEP:      step_q    <= cfg_wdata_i[LIM_W-1:0];
        CFG_TIMEOUT:   timeout_q <= cfg_wdata_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_type_q <= s_axis_tuser_i;
      for (int i = 0; i < AXES; i++) begin
        in_cmd_q[i] <= s_axis_tdata_i[i*RW +: RW];
      end
      in_ovr_q <= s_axis_tdata_i[4*RW +: RW];
    end
  end

  // desired rates
  always_comb begin
    ticks_d = (ticks_q != TICK_MAX) ? ticks_q + 1'b1 : ticks_q;
    stale   = ticks_d > timeout_q;
    for (int i = 0; i < AXES; i++) begin
      want[i] = stale ? '0 : target_q[i];
    end
    if (ovr_on_q) begin
      want[AX_Z] = ovr_q;
    end
    lim[0] = max_h_q;
    lim[1] = max_h_q;
    lim[2] = max_v_q;
    lim[3] = max_t_q;
  end

  for (genvar g = 0; g < AXES; g++) begin : g_axis
    vssl_axis #(.RW(RW)) u_axis (
      .cur_i  (cur_q[g]),
      .want_i (want[g]),
      .lim_i  (lim[g]),
      .step_i (step_q),
      .next_o (next_rate[g])
    );
  end

  // state update
  always_comb begin
    logic [TICK_W-1:0] ticks_n;
    ticks_n     = ticks_q;
    target_d    = target_q;
    cur_d       = cur_q;
    ovr_d       = ovr_q;
    ovr_on_d    = ovr_on_q;
    out_valid_d = m_axis_tready_i ? 1'b0 : out_valid_q;
    out_data_d  = out_data_q;
    if (fire) begin
      case (in_type_q)
        REQ_CMD: begin
          target_d = in_cmd_q;
          ticks_n  = '0;
        end
        REQ_OVERRIDE: begin
          ovr_d    = in_ovr_q;
          ovr_on_d = (in_ovr_q != '0);
        end
        REQ_TICK: begin
          ticks_n     = ticks_d;
          cur_d       = next_rate;
          out_valid_d = 1'b1;
          out_data_d  = '0;
          for (int i = 0; i < AXES; i++) begin
            out_data_d[i*RW +: RW] = next_rate[i];
          end
        end
        default: ;
      endcase
    end
    ticks_d_r = ticks_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXES; i++) begin
        target_q[i] <= '0;
        cur_q[i]    <= '0;
      end
      ovr_q       <= '0;
      ovr_on_q    <= 1'b0;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      target_q    <= target_d;
      cur_q       <= cur_d;
      ovr_q       <= ovr_d;
      ovr_on_q    <= ovr_on_d;
      ticks_q     <= ticks_d_r;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire && is_tick))
    else $error("result raised without a tick request");

  a_cmd_clears_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_type_q == REQ_CMD) |=> (ticks_q == '0))
    else $error("command did not restart tick counter");

  a_rates_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !is_tick |=> ($stable(cur_q[0]) && $stable(cur_q[1]) &&
                          $stable(cur_q[2]) && $stable(cur_q[3])))
    else $error("current rates changed on a non-tick request");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_data_q))
    else $error("pending result lost");

endmodule

// ----- bench/tb_velocity_setpoint_slew_limiter_unit.sv -----
// Self-checking bench for the velocity setpoint slew limiter: random and directed requests.
`timescale 1ns / 100ps

module tb_velocity_setpoint_slew_limiter_unit;
  import vssl_pkg::*;

  localparam logic [REQ_W-1:0]  REQ_UNUSED   = 2'd3;
  localparam logic [CFG_AW-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_SPARE_HI = 3'd7;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    logic [15:0]      ovz;
    logic [3:0][15:0] rate;
  } req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  velocity_setpoint_slew_limiter_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state and register copy
  logic [LIM_W-1:0]   lim_h = RST_MAX_HORIZ;
  logic [LIM_W-1:0]   lim_v = RST_MAX_VERT;
  logic [LIM_W-1:0]   lim_t = RST_MAX_TURN;
  logic [LIM_W-1:0]   step  = RST_STEP;
  logic [TICK_W-1:0]  tmo   = RST_TIMEOUT;
  logic signed [15:0] tgt_rate [4] = '{0, 0, 0, 0};
  logic signed [15:0] cur_rate [4] = '{0, 0, 0, 0};
  logic signed [15:0] ovr_rate = '0;
  logic               ovr_on = 1'b0;
  logic [TICK_W-1:0]  tick_cnt = '0;

  req_t        pending_req [$];
  logic [63:0] expected_rates [$];
  int          mismatches = 0;
  string       axis_name [4] = '{"vx", "vy", "vz", "yaw"};

  // idle knobs
  int  gap_max = 0;
  int  stall_max = 0;
  int  burst_left = 1;
  int  gap_left = 0;
  int  rdy_run = 0;
  bit  stalled = 1'b0;
  bit  req_taken = 1'b0;

  function automatic void apply_request(req_t r);
    int want [4];
    int lim;
    int c;
    int st;
    logic [63:0] res;
    res = '0;
    st = int'(step);
    case (r.kind)
      REQ_CMD: begin
        for (int i = 0; i < 4; i++) tgt_rate[i] = r.rate[i];
        tick_cnt = '0;
      end
      REQ_OVERRIDE: begin
        ovr_rate = r.ovz;
        ovr_on = (r.ovz != 16'd0);
      end
      REQ_TICK: begin
        if (tick_cnt != TICK_MAX) tick_cnt = tick_cnt + 1'b1;
        for (int i = 0; i < 4; i++) want[i] = (tick_cnt > tmo) ? 0 : int'(tgt_rate[i]);
        if (ovr_on) want[2] = int'(ovr_rate);
        for (int i = 0; i < 4; i++) begin
          lim = (i < 2) ? int'(lim_h) : (i == 2) ? int'(lim_v) : int'(lim_t);
          if (want[i] > lim) want[i] = lim;
          else if (want[i] < -lim) want[i] = -lim;
          c = int'(cur_rate[i]);
          if (want[i] > c) c = (c + st < want[i]) ? c + st : want[i];
          else c = (c - st > want[i]) ? c - st : want[i];
          cur_rate[i] = c[15:0];
          res[16*i +: 16] = c[15:0];
        end
        expected_rates.push_back(res);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready) begin
      apply_request(pending_req.pop_front());
      req_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && !(s_tvalid && !req_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_req.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {pending_req[0].ovz, pending_req[0].rate};
        s_tuser  <= pending_req[0].kind;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_max == 0) begin
        m_tready <= 1'b1;
      end else begin
        if (rdy_run == 0) begin
          stalled = !stalled;
          rdy_run = stalled ? $urandom_range(1, stall_max) : $urandom_range(1, 8);
        end
        rdy_run--;
        m_tready <= !stalled;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    logic [63:0] want_v;
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_rates.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        want_v = expected_rates.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (m_tdata[16*i +: 16] !== want_v[16*i +: 16]) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, axis_name[i],
                     $signed(want_v[16*i +: 16]), $signed(m_tdata[16*i +: 16]));
            mismatches++;
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAX_HORIZ: lim_h = val[LIM_W-1:0];
      CFG_MAX_VERT:  lim_v = val[LIM_W-1:0];
      CFG_MAX_TURN:  lim_t = val[LIM_W-1:0];
      CFG_STEP:      step  = val[LIM_W-1:0];
      CFG_TIMEOUT:   tmo   = val;
      default: ;
    endcase
  endtask

  task automatic drain_all();
    int n;
    n = 0;
    while ((pending_req.size() != 0 || expected_rates.size() != 0) && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    if (n == DRAIN_LIMIT) begin
      $display("%0t drain stuck: expected 0 pending, actual %0d results missing", $time,
               expected_rates.size());
      mismatches++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_rate();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4: return 16'(int'($urandom_range(0, 4000)) - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_t make_req(logic [REQ_W-1:0] kind);
    req_t r;
    r.kind = kind;
    r.ovz = rand_rate();
    for (int i = 0; i < 4; i++) r.rate[i] = rand_rate();
    return r;
  endfunction

  function automatic req_t make_cmd(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
                                    logic [15:0] yaw);
    req_t r;
    r = make_req(REQ_CMD);
    r.rate = {yaw, vz, vy, vx};
    return r;
  endfunction

  function automatic req_t make_ovr(logic [15:0] v);
    req_t r;
    r = make_req(REQ_OVERRIDE);
    r.ovz = v;
    return r;
  endfunction

  function automatic req_t rand_req(int tick_pct);
    req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < tick_pct) r = make_req(REQ_TICK);
    else if (pick < 95) begin
      if ($urandom_range(0, 2) != 0) r = make_req(REQ_CMD);
      else r = make_ovr(($urandom_range(0, 1) != 0) ? 16'h0000 : rand_rate());
    end else r = make_req(REQ_UNUSED);
    return r;
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(1, 3000));
    endcase
  endfunction

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults
    pending_req.push_back(make_req(REQ_TICK));
    pending_req.push_back(make_cmd(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
    pending_req.push_back(make_req(REQ_TICK));
    pending_req.push_back(make_req(REQ_TICK));
    pending_req.push_back(make_ovr(16'h8000));
    pending_req.push_back(make_req(REQ_TICK));
    pending_req.push_back(make_ovr(16'h0000));
    pending_req.push_back(make_req(REQ_TICK));
    pending_req.push_back(make_req(REQ_UNUSED));
    pending_req.push_back(make_req(REQ_TICK));
    drain_all();

    // full-scale limits, masked writes, spare indexes
    write_reg(CFG_MAX_HORIZ, 16'hFFFF);
    write_reg(CFG_MAX_VERT, 16'hFFFF);
    write_reg(CFG_MAX_TURN, 16'hFFFF);
    write_reg(CFG_STEP, 16'hFFFF);
    write_reg(CFG_TIMEOUT, 16'd1);
    write_reg(CFG_SPARE_LO, 16'h0000);
    write_reg(CFG_SPARE_HI, 16'hFFFF);
    pending_req.push_back(make_cmd(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    pending_req.push_back(make_req(REQ_TICK));
    pending_req.push_back(make_req(REQ_TICK));
    pending_req.push_back(make_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    pending_req.push_back(make_req(REQ_TICK));
    pending_req.push_back(make_ovr(16'h8000));
    pending_req.push_back(make_req(REQ_TICK));
    drain_all();
    write_reg(CFG_TIMEOUT, 16'd0);
    pending_req.push_back(make_cmd(16'h1234, 16'hEDCB, 16'h0100, 16'hFF00));
    pending_req.push_back(make_req(REQ_TICK));
    drain_all();

    // zero limits, zero step
    write_reg(CFG_MAX_HORIZ, 16'd0);
    write_reg(CFG_MAX_VERT, 16'd0);
    write_reg(CFG_MAX_TURN, 16'd0);
    write_reg(CFG_STEP, 16'd0);
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    pending_req.push_back(make_cmd(16'd1000, 16'hFC18, 16'd500, 16'd700));
    pending_req.push_back(make_req(REQ_TICK));
    drain_all();
    write_reg(CFG_STEP, 16'd5);
    pending_req.push_back(make_req(REQ_TICK));
    pending_req.push_back(make_req(REQ_TICK));
    drain_all();

    for (int p = 0; p < 6; p++) begin
      gap_max   = (p == 0) ? 0 : $urandom_range(1, 20);
      stall_max = (p == 0) ? 0 : $urandom_range(1, 12);
      write_reg(CFG_MAX_HORIZ, pick_limit());
      write_reg(CFG_MAX_VERT, pick_limit());
      write_reg(CFG_MAX_TURN, pick_limit());
      case ($urandom_range(0, 5))
        0: write_reg(CFG_STEP, 16'd0);
        1: write_reg(CFG_STEP, 16'd1);
        2: write_reg(CFG_STEP, 16'h7FFF);
        default: write_reg(CFG_STEP, 16'($urandom_range(1, 400)));
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(CFG_TIMEOUT, 16'd0);
        1: write_reg(CFG_TIMEOUT, 16'hFFFF);
        default: write_reg(CFG_TIMEOUT, 16'($urandom_range(1, 24)));
      endcase
      for (int k = 0; k < 330; k++) pending_req.push_back(rand_req($urandom_range(40, 90)));
      drain_all();
    end

    // long run of ticks after one command, across the timeout
    gap_max = 0;
    stall_max = 0;
    write_reg(CFG_TIMEOUT, 16'd20);
    write_reg(CFG_STEP, 16'd100);
    write_reg(CFG_MAX_HORIZ, 16'd2000);
    pending_req.push_back(make_cmd(16'd1500, 16'hFA24, 16'd300, 16'd900));
    for (int k = 0; k < 40; k++) pending_req.push_back(make_req(REQ_TICK));
    drain_all();

    if (mismatches == 0) begin
      $display("[velocity_setpoint_slew_limiter_unit] OK");
    end else begin
      $display("[velocity_setpoint_slew_limiter_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[velocity_setpoint_slew_limiter_unit] ERROR");
    $finish;
  end

endmodule

// ----- velocity_setpoint_slew_limiter_unit.f -----
rtl/core/vssl_pkg.sv
rtl/core/vssl_axis.sv
rtl/core/velocity_setpoint_slew_limiter_unit.sv
bench/tb_velocity_setpoint_slew_limiter_unit.sv
